>>> hw/rtl/key_value_line_parser_unit_assert.svh
// assertion macros for the key/value line parser
`ifndef KEY_VALUE_LINE_PARSER_UNIT_ASSERT_SVH
`define KEY_VALUE_LINE_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define KVLP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kvlp assertion failed");

// next-cycle implication
`define KVLP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kvlp assertion failed");

`endif

>>> hw/rtl/kvlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kvlp_pkg;

  localparam int LINE_BUFFER_BYTES = 128;
  localparam int LINE_LIMIT        = LINE_BUFFER_BYTES - 2;
  localparam int LEN_W             = $clog2(LINE_LIMIT + 1);
  localparam int SP_W              = 7;
  localparam logic [SP_W-1:0] SP_MAX = {SP_W{1'b1}};

  // result queue
  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef enum logic [2:0] {
    K_KEY_CHAR = 3'd0,
    K_VAL_CHAR = 3'd1,
    K_KEY_END  = 3'd2,
    K_PAIR_END = 3'd3,
    K_DONE     = 3'd4,
    K_ERROR    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ERR_LONG      = 2'd0,
    ERR_NO_SEP    = 2'd1,
    ERR_EMPTY_KEY = 2'd2
  } err_t;

  typedef enum logic [6:0] {
    M_LEAD    = 7'b0000001,
    M_KEY     = 7'b0000010,
    M_VLEAD   = 7'b0000100,
    M_VALUE   = 7'b0001000,
    M_COMMENT = 7'b0010000,
    M_HALT    = 7'b0100000,
    M_BADKEY  = 7'b1000000
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [LEN_W-1:0] len;
    logic [SP_W-1:0]  sp_pend;  // pending interior spaces, or those before a held cr
    logic             cr_held;
    logic [SP_W-1:0]  sp_after; // spaces after a held cr
    logic             key_seen;
  } state_t;

  localparam state_t ST_RESET = '{mode: M_LEAD, default: '0};

  typedef struct packed {
    kind_t           kind;
    logic [7:0]      ch;
    logic [SP_W-1:0] sp;
    err_t            err;
  } res_t;

  // next state plus up to two results for one request
  typedef struct packed {
    state_t          st;
    logic [1:0]      n;
    res_t [1:0]      res;
  } acc_t;

endpackage

`default_nettype wire

>>> hw/rtl/kvlp_step.sv
`timescale 1ns / 1ps
`default_nettype none

module kvlp_step (
  input  wire kvlp_pkg::state_t st_cur,
  input  wire logic [7:0]       byte_value,
  input  wire logic             end_of_input,
  output kvlp_pkg::acc_t        acc
);

  function automatic kvlp_pkg::acc_t push(kvlp_pkg::acc_t a, kvlp_pkg::kind_t k,
                                          logic [7:0] ch, logic [kvlp_pkg::SP_W-1:0] sp,
                                          kvlp_pkg::err_t e);
    kvlp_pkg::acc_t r;
    r = a;
    r.res[a.n[0]] = '{kind: k, ch: ch, sp: sp, err: e};
    r.n = a.n + 2'd1;
    return r;
  endfunction

  function automatic kvlp_pkg::acc_t fail(kvlp_pkg::acc_t a, kvlp_pkg::err_t e);
    kvlp_pkg::acc_t r;
    r = push(a, kvlp_pkg::K_ERROR, 8'd0, '0, e);
    r.st.mode = kvlp_pkg::M_HALT;
    return r;
  endfunction

  function automatic kvlp_pkg::acc_t flush_cr(kvlp_pkg::acc_t a, kvlp_pkg::kind_t k);
    kvlp_pkg::acc_t r;
    r = a;
    if (a.st.cr_held) begin
      r = push(r, k, kvlp_pkg::CH_CR, a.st.sp_pend, kvlp_pkg::ERR_LONG);
      r.st.sp_pend  = a.st.sp_after;
      r.st.sp_after = '0;
      r.st.cr_held  = 1'b0;
      if (k == kvlp_pkg::K_KEY_CHAR) r.st.key_seen = 1'b1;
    end
    return r;
  endfunction

  function automatic kvlp_pkg::acc_t emit_char(kvlp_pkg::acc_t a, kvlp_pkg::kind_t k,
                                               logic [7:0] ch);
    kvlp_pkg::acc_t r;
    r = flush_cr(a, k);
    r = push(r, k, ch, r.st.sp_pend, kvlp_pkg::ERR_LONG);
    r.st.sp_pend = '0;
    if (k == kvlp_pkg::K_KEY_CHAR) r.st.key_seen = 1'b1;
    return r;
  endfunction

  function automatic kvlp_pkg::acc_t add_space(kvlp_pkg::acc_t a);
    kvlp_pkg::acc_t r;
    r = a;
    if (a.st.cr_held) begin
      if (a.st.sp_after != kvlp_pkg::SP_MAX) r.st.sp_after = a.st.sp_after + 1'b1;
    end else begin
      if (a.st.sp_pend != kvlp_pkg::SP_MAX) r.st.sp_pend = a.st.sp_pend + 1'b1;
    end
    return r;
  endfunction

  function automatic kvlp_pkg::acc_t hold_cr(kvlp_pkg::acc_t a);
    kvlp_pkg::acc_t r;
    r = a;
    r.st.cr_held  = 1'b1;
    r.st.sp_after = '0;
    return r;
  endfunction

  kvlp_pkg::acc_t a;
  logic           is_lf, is_cr, is_sp, is_hash, is_eq;

  assign is_lf   = (byte_value == kvlp_pkg::CH_LF);
  assign is_cr   = (byte_value == kvlp_pkg::CH_CR);
  assign is_sp   = (byte_value == kvlp_pkg::CH_SPACE);
  assign is_hash = (byte_value == kvlp_pkg::CH_HASH);
  assign is_eq   = (byte_value == kvlp_pkg::CH_EQ);

  always_comb begin
    a    = '0;
    a.st = st_cur;
    if (st_cur.mode == kvlp_pkg::M_HALT) begin
      a.n = 2'd0;
    end else if (end_of_input) begin
      if (st_cur.len != '0) begin
        a = fail(a, kvlp_pkg::ERR_LONG);
      end else begin
        a = push(a, kvlp_pkg::K_DONE, 8'd0, '0, kvlp_pkg::ERR_LONG);
        a.st.mode = kvlp_pkg::M_HALT;
      end
    end else if (!is_lf && (st_cur.len >= kvlp_pkg::LEN_W'(kvlp_pkg::LINE_LIMIT))) begin
      a = fail(a, kvlp_pkg::ERR_LONG);
    end else begin
      if (!is_lf) a.st.len = st_cur.len + 1'b1;
      unique case (st_cur.mode)
        kvlp_pkg::M_LEAD: begin
          priority if (is_lf) a.st = kvlp_pkg::ST_RESET;
          else if (is_sp) a.n = 2'd0;
          else if (is_cr) begin
            a.st.mode    = kvlp_pkg::M_KEY;
            a.st.sp_pend = '0;
            a = hold_cr(a);
          end
          else if (is_hash) a.st.mode = kvlp_pkg::M_COMMENT;
          else if (is_eq) a.st.mode = kvlp_pkg::M_BADKEY;
          else begin
            a.st.mode = kvlp_pkg::M_KEY;
            a = emit_char(a, kvlp_pkg::K_KEY_CHAR, byte_value);
          end
        end
        kvlp_pkg::M_KEY: begin
          priority if (is_sp) a = add_space(a);
          else if (is_cr) begin
            a = flush_cr(a, kvlp_pkg::K_KEY_CHAR);
            a = hold_cr(a);
          end
          else if (is_lf) begin
            // a lone cr on the line is a blank line
            if (!st_cur.key_seen && st_cur.cr_held && st_cur.sp_after == '0)
              a.st = kvlp_pkg::ST_RESET;
            else
              a = fail(a, kvlp_pkg::ERR_NO_SEP);
          end
          else if (is_eq) begin
            a = flush_cr(a, kvlp_pkg::K_KEY_CHAR);
            if (a.st.key_seen) begin
              a = push(a, kvlp_pkg::K_KEY_END, 8'd0, '0, kvlp_pkg::ERR_LONG);
              a.st.mode    = kvlp_pkg::M_VLEAD;
              a.st.sp_pend = '0;
            end else begin
              a.st.mode = kvlp_pkg::M_BADKEY;
            end
          end
          else a = emit_char(a, kvlp_pkg::K_KEY_CHAR, byte_value);
        end
        kvlp_pkg::M_VLEAD: begin
          priority if (is_sp) a.n = 2'd0;
          else if (is_lf) begin
            a = push(a, kvlp_pkg::K_PAIR_END, 8'd0, '0, kvlp_pkg::ERR_LONG);
            a.st = kvlp_pkg::ST_RESET;
          end
          else if (is_cr) begin
            a.st.mode    = kvlp_pkg::M_VALUE;
            a.st.sp_pend = '0;
            a = hold_cr(a);
          end
          else begin
            a.st.mode    = kvlp_pkg::M_VALUE;
            a.st.sp_pend = '0;
            a = emit_char(a, kvlp_pkg::K_VAL_CHAR, byte_value);
          end
        end
        kvlp_pkg::M_VALUE: begin
          priority if (is_sp) a = add_space(a);
          else if (is_cr) begin
            a = flush_cr(a, kvlp_pkg::K_VAL_CHAR);
            a = hold_cr(a);
          end
          else if (is_lf) begin
            // cr followed by spaces is a real character, cr right before lf is not
            if (st_cur.cr_held && st_cur.sp_after != '0)
              a = flush_cr(a, kvlp_pkg::K_VAL_CHAR);
            a = push(a, kvlp_pkg::K_PAIR_END, 8'd0, '0, kvlp_pkg::ERR_LONG);
            a.st = kvlp_pkg::ST_RESET;
          end
          else a = emit_char(a, kvlp_pkg::K_VAL_CHAR, byte_value);
        end
        kvlp_pkg::M_COMMENT: begin
          if (is_lf) a.st = kvlp_pkg::ST_RESET;
        end
        kvlp_pkg::M_BADKEY: begin
          if (is_lf) a = fail(a, kvlp_pkg::ERR_EMPTY_KEY);
        end
        default: a.st.mode = kvlp_pkg::M_HALT;
      endcase
    end
  end

  assign acc = a;

endmodule

`default_nettype wire

>>> hw/rtl/key_value_line_parser_unit.sv
// path: an accepted request is held in the input stage, then its results enter the result queue, which drives out_valid
// throughput: one request per cycle while the queue has room for two results; a request that yields
//   two results takes two queue slots, so a stream of them is paced by the single output port
// reset: synchronous active-low rst_n clears the stage, the result queue and the
//   parser state to leading-space mode with zero counts
`timescale 1ns / 1ps
`default_nettype none
`include "key_value_line_parser_unit_assert.svh"

module key_value_line_parser_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte_value,
  input  wire logic       in_end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_char_out,
  output logic [6:0]      out_spaces_before,
  output logic [1:0]      out_error_code
);

  logic                          stg_v_r;
  logic [7:0]                    stg_byte_r;
  logic                          stg_eoi_r;
  kvlp_pkg::state_t              state_r;
  kvlp_pkg::acc_t                acc;
  kvlp_pkg::res_t                q_r [kvlp_pkg::QDEPTH];
  logic [kvlp_pkg::PTR_W-1:0]    wr_ptr_r, rd_ptr_r, wr_ptr1;
  logic [kvlp_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [1:0]                    push_n;
  logic                          advance, pop;
  kvlp_pkg::res_t                head;

  kvlp_step u_step (
    .st_cur      (state_r),
    .byte_value  (stg_byte_r),
    .end_of_input(stg_eoi_r),
    .acc         (acc)
  );

  // the staged request moves on only when the queue can take two results
  assign advance  = stg_v_r && (cnt_r <= kvlp_pkg::CNT_W'(kvlp_pkg::QDEPTH - 2));
  assign in_ready = !stg_v_r || advance;
  assign pop      = out_valid && out_ready;
  assign push_n   = advance ? acc.n : 2'd0;
  assign wr_ptr1  = wr_ptr_r + 1'b1;
  assign cnt_nxt  = cnt_r + kvlp_pkg::CNT_W'(push_n) - kvlp_pkg::CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r  <= 1'b0;
      state_r  <= kvlp_pkg::ST_RESET;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_ready) stg_v_r <= in_valid;
      if (advance) state_r <= acc.st;
      wr_ptr_r <= wr_ptr_r + kvlp_pkg::PTR_W'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_byte_r <= in_byte_value;
      stg_eoi_r  <= in_end_of_input;
    end
    if (push_n != 2'd0) q_r[wr_ptr_r] <= acc.res[0];
    if (push_n == 2'd2) q_r[wr_ptr1] <= acc.res[1];
  end

  assign head              = q_r[rd_ptr_r];
  assign out_valid         = (cnt_r != '0);
  assign out_kind          = head.kind;
  assign out_char_out      = head.ch;
  assign out_spaces_before = head.sp;
  assign out_error_code    = head.err;

  `KVLP_ASSERT_IMP(a_queue_bound, 1'b1, cnt_r <= kvlp_pkg::CNT_W'(kvlp_pkg::QDEPTH))
  `KVLP_ASSERT_NXT(a_halt_sticky, state_r.mode == kvlp_pkg::M_HALT, state_r.mode == kvlp_pkg::M_HALT)
  `KVLP_ASSERT_IMP(a_halt_silent, state_r.mode == kvlp_pkg::M_HALT, acc.n == 2'd0)
  `KVLP_ASSERT_NXT(a_stage_hold, stg_v_r && !advance, stg_v_r && $stable(stg_byte_r) && $stable(stg_eoi_r))

endmodule

`default_nettype wire

>>> sim/key_value_line_parser_unit_test.sv
`timescale 1ns / 1ps

module key_value_line_parser_unit_test;

  localparam int IDLE_LIMIT   = 2000;
  localparam int STREAM_BYTES = 1250;
  localparam int SHOW_MAX     = 10;
  localparam int DRAIN_CYCLES = 10;
  // error field reads zero on every result that is not an error
  localparam kvlp_pkg::err_t ERR_NONE = kvlp_pkg::ERR_LONG;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte_value;
  logic       in_end_of_input;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_kind;
  logic [7:0] out_char_out;
  logic [6:0] out_spaces_before;
  logic [1:0] out_error_code;

  class parse_scoreboard;
    kvlp_pkg::mode_t           mode;
    int unsigned               len;
    logic [kvlp_pkg::SP_W-1:0] sp_pend;
    bit                        cr_held;
    logic [kvlp_pkg::SP_W-1:0] sp_after;
    bit                        key_seen;
    kvlp_pkg::res_t            pending_q[$];
    int unsigned               requests;
    int unsigned               checked;
    int unsigned               faults;
    int unsigned               pairs;
    string                     closing;

    function new();
      start_line();
      closing = "nothing";
    endfunction

    function void start_line();
      mode = kvlp_pkg::M_LEAD;
      len = 0;
      sp_pend = '0;
      cr_held = 0;
      sp_after = '0;
      key_seen = 0;
    endfunction

    function void push(kvlp_pkg::kind_t k, logic [7:0] ch, logic [kvlp_pkg::SP_W-1:0] sp,
                       kvlp_pkg::err_t e);
      kvlp_pkg::res_t r;
      r.kind = k;
      r.ch = ch;
      r.sp = sp;
      r.err = e;
      pending_q.push_back(r);
    endfunction

    function void count_space();
      if (cr_held) begin
        if (sp_after < kvlp_pkg::SP_MAX) sp_after++;
      end else if (sp_pend < kvlp_pkg::SP_MAX) begin
        sp_pend++;
      end
    endfunction

    function void hold_cr();
      cr_held = 1;
      sp_after = '0;
    endfunction

    // a held cr turns into an ordinary character of the current field
    function void release_cr(kvlp_pkg::kind_t k);
      if (!cr_held) return;
      push(k, kvlp_pkg::CH_CR, sp_pend, ERR_NONE);
      sp_pend = sp_after;
      sp_after = '0;
      cr_held = 0;
      if (k == kvlp_pkg::K_KEY_CHAR) key_seen = 1;
    endfunction

    function void put_char(kvlp_pkg::kind_t k, logic [7:0] ch);
      release_cr(k);
      push(k, ch, sp_pend, ERR_NONE);
      sp_pend = '0;
      if (k == kvlp_pkg::K_KEY_CHAR) key_seen = 1;
    endfunction

    function void stop_with(kvlp_pkg::err_t e);
      push(kvlp_pkg::K_ERROR, 8'h00, '0, e);
      mode = kvlp_pkg::M_HALT;
    endfunction

    function void note_request(logic [7:0] b, logic eoi);
      requests++;
      if (mode == kvlp_pkg::M_HALT) return;
      if (eoi) begin
        if (len > 0) begin
          stop_with(kvlp_pkg::ERR_LONG);
        end else begin
          push(kvlp_pkg::K_DONE, 8'h00, '0, ERR_NONE);
          mode = kvlp_pkg::M_HALT;
        end
        return;
      end
      if (b != kvlp_pkg::CH_LF) begin
        if (len >= kvlp_pkg::LINE_LIMIT) begin
          stop_with(kvlp_pkg::ERR_LONG);
          return;
        end
        len++;
      end
      case (mode)
        kvlp_pkg::M_LEAD: begin
          if (b == kvlp_pkg::CH_LF) start_line();
          else if (b == kvlp_pkg::CH_CR) begin
            mode = kvlp_pkg::M_KEY;
            sp_pend = '0;
            hold_cr();
          end else if (b == kvlp_pkg::CH_HASH) mode = kvlp_pkg::M_COMMENT;
          else if (b == kvlp_pkg::CH_EQ) mode = kvlp_pkg::M_BADKEY;
          else if (b != kvlp_pkg::CH_SPACE) begin
            mode = kvlp_pkg::M_KEY;
            put_char(kvlp_pkg::K_KEY_CHAR, b);
          end
        end
        kvlp_pkg::M_KEY: begin
          if (b == kvlp_pkg::CH_SPACE) count_space();
          else if (b == kvlp_pkg::CH_CR) begin
            release_cr(kvlp_pkg::K_KEY_CHAR);
            hold_cr();
          end else if (b == kvlp_pkg::CH_LF) begin
            // cr then lf with nothing else is a blank line
            if (!key_seen && cr_held && sp_after == 0) start_line();
            else stop_with(kvlp_pkg::ERR_NO_SEP);
          end else if (b == kvlp_pkg::CH_EQ) begin
            release_cr(kvlp_pkg::K_KEY_CHAR);
            if (key_seen) begin
              push(kvlp_pkg::K_KEY_END, 8'h00, '0, ERR_NONE);
              mode = kvlp_pkg::M_VLEAD;
              sp_pend = '0;
            end else begin
              mode = kvlp_pkg::M_BADKEY;
            end
          end else put_char(kvlp_pkg::K_KEY_CHAR, b);
        end
        kvlp_pkg::M_VLEAD: begin
          if (b == kvlp_pkg::CH_LF) begin
            push(kvlp_pkg::K_PAIR_END, 8'h00, '0, ERR_NONE);
            start_line();
          end else if (b == kvlp_pkg::CH_CR) begin
            mode = kvlp_pkg::M_VALUE;
            sp_pend = '0;
            hold_cr();
          end else if (b != kvlp_pkg::CH_SPACE) begin
            mode = kvlp_pkg::M_VALUE;
            sp_pend = '0;
            put_char(kvlp_pkg::K_VAL_CHAR, b);
          end
        end
        kvlp_pkg::M_VALUE: begin
          if (b == kvlp_pkg::CH_SPACE) count_space();
          else if (b == kvlp_pkg::CH_CR) begin
            release_cr(kvlp_pkg::K_VAL_CHAR);
            hold_cr();
          end else if (b == kvlp_pkg::CH_LF) begin
            if (cr_held && sp_after != 0) release_cr(kvlp_pkg::K_VAL_CHAR);
            push(kvlp_pkg::K_PAIR_END, 8'h00, '0, ERR_NONE);
            start_line();
          end else put_char(kvlp_pkg::K_VAL_CHAR, b);
        end
        kvlp_pkg::M_COMMENT: begin
          if (b == kvlp_pkg::CH_LF) start_line();
        end
        kvlp_pkg::M_BADKEY: begin
          if (b == kvlp_pkg::CH_LF) stop_with(kvlp_pkg::ERR_EMPTY_KEY);
        end
        default: mode = kvlp_pkg::M_HALT;
      endcase
    endfunction

    function void check_result(logic [2:0] k, logic [7:0] c, logic [6:0] s, logic [1:0] e);
      kvlp_pkg::res_t want;
      if (pending_q.size() == 0) begin
        faults++;
        if (faults <= SHOW_MAX)
          $display("unexpected result: kind %0d char %02h spaces %0d err %0d", k, c, s, e);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (k !== want.kind || c !== want.ch || s !== want.sp || e !== want.err) begin
        faults++;
        if (faults <= SHOW_MAX)
          $display("mismatch: expected kind %0d char %02h spaces %0d err %0d, got %0d %02h %0d %0d",
                   want.kind, want.ch, want.sp, want.err, k, c, s, e);
      end
      if (want.kind == kvlp_pkg::K_PAIR_END) pairs++;
      if (want.kind == kvlp_pkg::K_DONE) closing = "end of input";
      if (want.kind == kvlp_pkg::K_ERROR) closing = $sformatf("error code %0d", want.err);
    endfunction
  endclass

  parse_scoreboard sb;
  logic [7:0]      line_q[$];
  bit              send_burst;
  int              idle_cycles;

  key_value_line_parser_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_value     (in_byte_value),
    .in_end_of_input   (in_end_of_input),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_char_out      (out_char_out),
    .out_spaces_before (out_spaces_before),
    .out_error_code    (out_error_code)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // text byte biased toward the characters the parser cares about
  function automatic logic [7:0] text_byte(input bit allow_eq);
    logic [7:0] b;
    do begin
      case ($urandom_range(0, 9))
        0, 1, 2: b = kvlp_pkg::CH_SPACE;
        3:       b = kvlp_pkg::CH_CR;
        4:       b = kvlp_pkg::CH_HASH;
        5:       b = kvlp_pkg::CH_EQ;
        default: b = 8'($urandom_range(0, 255));
      endcase
    end while (b == kvlp_pkg::CH_LF || (!allow_eq && b == kvlp_pkg::CH_EQ));
    return b;
  endfunction

  // first byte of a key: must not look like a comment or a blank
  function automatic logic [7:0] key_lead_byte();
    logic [7:0] b;
    do b = text_byte(1'b0); while (b == kvlp_pkg::CH_SPACE || b == kvlp_pkg::CH_HASH);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i], 1'b0);
    line_q.delete();
  endtask

  // '~' stands for cr and '|' for lf
  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      if (s[i] == "~") line_q.push_back(kvlp_pkg::CH_CR);
      else if (s[i] == "|") line_q.push_back(kvlp_pkg::CH_LF);
      else line_q.push_back(s[i]);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_byte_value, in_end_of_input);
      if (out_valid && out_ready)
        sb.check_result(out_kind, out_char_out, out_spaces_before, out_error_code);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no handshake for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int  stall;
    bit  burst;
    out_ready = 1'b0;
    burst = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      stall = burst ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int         n;
    int         room;
    int         trail_sp;
    int         cr_sp;
    bit         tail_cr;
    logic [7:0] b;

    sb = new();
    idle_cycles = 0;
    send_burst = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte_value = 8'h00;
    in_end_of_input = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // trimming, interior spaces, crlf, held cr in key and value, byte extremes,
    // cr-only blank line, comment
    put_text(" a  b = c ~|");
    put_text("~#=~ |");
    line_q.push_back(8'h00);
    put_text("=");
    line_q.push_back(8'hFF);
    put_text("|~|#|");
    send_line();

    while (sb.requests < STREAM_BYTES) begin
      n = $urandom_range(0, 19);
      if (n < 14) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        repeat (n) line_q.push_back(kvlp_pkg::CH_SPACE);
        line_q.push_back(key_lead_byte());
        repeat ($urandom_range(0, 7)) line_q.push_back(text_byte(1'b0));
        line_q.push_back(kvlp_pkg::CH_EQ);
        trail_sp = $urandom_range(0, 2);
        tail_cr = ($urandom_range(0, 2) == 0);
        cr_sp = (tail_cr && $urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        room = kvlp_pkg::LINE_LIMIT - line_q.size() - trail_sp - tail_cr - cr_sp;
        if ($urandom_range(0, 15) == 0) begin
          // full-length line, often with one long interior space run
          if ($urandom_range(0, 1) == 0) begin
            line_q.push_back(key_lead_byte());
            repeat (room - 2) line_q.push_back(kvlp_pkg::CH_SPACE);
            line_q.push_back(key_lead_byte());
          end else begin
            repeat (room) line_q.push_back(text_byte(1'b1));
          end
        end else begin
          repeat ($urandom_range(0, (room < 12) ? room : 12))
            line_q.push_back(text_byte(1'b1));
        end
        repeat (trail_sp) line_q.push_back(kvlp_pkg::CH_SPACE);
        if (tail_cr) begin
          line_q.push_back(kvlp_pkg::CH_CR);
          repeat (cr_sp) line_q.push_back(kvlp_pkg::CH_SPACE);
        end
        line_q.push_back(kvlp_pkg::CH_LF);
      end else if (n < 17) begin
        repeat ($urandom_range(0, 3)) line_q.push_back(kvlp_pkg::CH_SPACE);
        line_q.push_back(kvlp_pkg::CH_HASH);
        repeat ($urandom_range(0, 20)) line_q.push_back(text_byte(1'b1));
        line_q.push_back(kvlp_pkg::CH_LF);
      end else begin
        repeat ($urandom_range(0, 3)) line_q.push_back(kvlp_pkg::CH_SPACE);
        if ($urandom_range(0, 1) == 0) line_q.push_back(kvlp_pkg::CH_CR);
        line_q.push_back(kvlp_pkg::CH_LF);
      end
      send_line();
    end

    // one way of closing the stream, then a few requests that must be ignored
    case ($urandom_range(0, 4))
      0: send_byte(8'($urandom_range(0, 255)), 1'b1);
      1: begin
        repeat ($urandom_range(1, 8)) line_q.push_back(text_byte(1'b1));
        send_line();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      2: begin
        repeat (kvlp_pkg::LINE_LIMIT + 1) line_q.push_back(text_byte(1'b1));
        line_q.push_back(kvlp_pkg::CH_LF);
        send_line();
      end
      3: begin
        if ($urandom_range(0, 1) == 0) begin
          do b = key_lead_byte(); while (b == kvlp_pkg::CH_CR);
          line_q.push_back(b);
          repeat ($urandom_range(0, 5)) line_q.push_back(text_byte(1'b0));
        end else begin
          line_q.push_back(kvlp_pkg::CH_CR);
          repeat ($urandom_range(1, 3)) line_q.push_back(kvlp_pkg::CH_SPACE);
        end
        line_q.push_back(kvlp_pkg::CH_LF);
        send_line();
      end
      default: begin
        repeat ($urandom_range(0, 3)) line_q.push_back(kvlp_pkg::CH_SPACE);
        line_q.push_back(kvlp_pkg::CH_EQ);
        repeat ($urandom_range(0, 10)) line_q.push_back(text_byte(1'b1));
        line_q.push_back(kvlp_pkg::CH_LF);
        send_line();
      end
    endcase
    repeat (5) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;
    @(posedge clk);

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes sent, %0d results checked, %0d key/value lines completed",
             sb.requests, sb.checked, sb.pairs);
    $display("stream closed by %s, %0d mismatches", sb.closing, sb.faults);
    if (sb.faults == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
